### design/pmpe_pkg.sv
// types and constants shared by the plus/minus/paren expression evaluator
// no dependencies
`timescale 1ns / 1ps

package pmpe_pkg;

  localparam int VALUE_W = 32;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      error;
  } out_item_t;

  typedef struct packed {
    logic               sign;
    logic [VALUE_W-1:0] total;
  } stk_entry_t;

  localparam int STK_ENTRY_W = $bits(stk_entry_t);

  typedef struct packed {
    logic       clear;
    logic       push;
    logic       pop;
    stk_entry_t data;
  } stk_cmd_t;

endpackage

### design/plus_minus_paren_expression_evaluator.sv
// plus/minus/paren expression evaluator, one character per transfer
// latency: the result is valid the cycle after the last character's transfer
// throughput: one character per cycle while the output is not stalled; the stack ram read is prefetched
// reset: synchronous, clears totals, depth and output valid; stack ram is not cleared
// depends on pmpe_pkg and pmpe_stack
`timescale 1ns / 1ps

module plus_minus_paren_expression_evaluator #(
  parameter int MAX_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pmpe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pmpe_pkg::out_item_t out_data
);
  import pmpe_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);

  logic [VALUE_W-1:0] rt_r, rt_nxt;
  logic [VALUE_W-1:0] cn_r, cn_nxt;
  logic               ps_r, ps_nxt;
  logic               err_r, err_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  stk_cmd_t           cmd;
  logic [DW-1:0]      depth, depth_after;
  stk_entry_t         top;

  logic               accept;
  logic [7:0]         c;
  logic [VALUE_W-1:0] folded, fin_v, digit;
  logic               fin_err;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign c        = in_data.char_code;
  assign digit    = VALUE_W'(c - CH_ZERO);
  assign folded   = ps_r ? (rt_r - cn_r) : (rt_r + cn_r);

  always_comb begin
    rt_nxt        = rt_r;
    cn_nxt        = cn_r;
    ps_nxt        = ps_r;
    err_nxt       = err_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    depth_after   = depth;
    fin_v         = '0;
    fin_err       = 1'b0;
    if (accept) begin
      priority if (c >= CH_ZERO && c <= CH_NINE) begin
        cn_nxt = (cn_r << 3) + (cn_r << 1) + digit;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        rt_nxt = folded;
        cn_nxt = '0;
        ps_nxt = (c == CH_MINUS);
      end else if (c == CH_OPEN) begin
        if (depth == DW'(MAX_DEPTH)) begin
          err_nxt = 1'b1;
        end else begin
          cmd.push       = 1'b1;
          cmd.data.sign  = ps_r;
          cmd.data.total = rt_r;
          depth_after    = depth + 1'b1;
          rt_nxt         = '0;
          cn_nxt         = '0;
          ps_nxt         = 1'b0;
        end
      end else if (c == CH_CLOSE) begin
        cn_nxt = '0;
        ps_nxt = 1'b0;
        if (depth == '0) begin
          err_nxt = 1'b1;
          rt_nxt  = folded;
        end else begin
          cmd.pop     = 1'b1;
          depth_after = depth - 1'b1;
          rt_nxt      = top.sign ? (top.total - folded) : (top.total + folded);
        end
      end else if (c == CH_SPACE) begin
      end else begin
        err_nxt = 1'b1;
      end

      if (in_data.last_char) begin
        fin_v         = ps_nxt ? (rt_nxt - cn_nxt) : (rt_nxt + cn_nxt);
        fin_err       = err_nxt || (depth_after != '0);
        out_nxt.value = fin_err ? '0 : fin_v;
        out_nxt.error = fin_err;
        out_valid_nxt = 1'b1;
        cmd.clear     = 1'b1;
        rt_nxt        = '0;
        cn_nxt        = '0;
        ps_nxt        = 1'b0;
        err_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_r        <= '0;
      cn_r        <= '0;
      ps_r        <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rt_r        <= rt_nxt;
      cn_r        <= cn_nxt;
      ps_r        <= ps_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  pmpe_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .depth (depth),
    .top   (top)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### design/pmpe_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module pmpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/pmpe_stack.sv
// paren stack: top entry in a register, lower entries in pmpe_ram
// depends on pmpe_pkg and pmpe_ram
`timescale 1ns / 1ps

module pmpe_stack #(
  parameter int MAX_DEPTH = 16,
  localparam int DW = $clog2(MAX_DEPTH + 1),
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pmpe_pkg::stk_cmd_t    cmd,
  output logic [DW-1:0]         depth,
  output pmpe_pkg::stk_entry_t  top
);
  import pmpe_pkg::*;

  logic [DW-1:0]          depth_r, depth_nxt;
  stk_entry_t             top_r, top_nxt;
  logic                   fwd_valid_r, fwd_valid_nxt;
  stk_entry_t             fwd_data_r;
  logic                   wr_en;
  logic [DW-1:0]          wr_idx, rd_idx;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [STK_ENTRY_W-1:0] rd_data;
  stk_entry_t             below;

  assign below = fwd_valid_r ? fwd_data_r : stk_entry_t'(rd_data);

  always_comb begin
    depth_nxt = depth_r;
    top_nxt   = top_r;
    wr_en     = 1'b0;
    priority if (cmd.clear) begin
      depth_nxt = '0;
    end else if (cmd.push) begin
      depth_nxt = depth_r + 1'b1;
      top_nxt   = cmd.data;
      wr_en     = (depth_r != '0);
    end else if (cmd.pop) begin
      depth_nxt = depth_r - 1'b1;
      top_nxt   = below;
    end else begin
      depth_nxt = depth_r;
    end
    wr_idx        = depth_r - 1'b1;
    rd_idx        = depth_nxt - DW'(2);
    wr_addr       = wr_idx[AW-1:0];
    rd_addr       = rd_idx[AW-1:0];
    fwd_valid_nxt = wr_en && (wr_addr == rd_addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      fwd_valid_r <= fwd_valid_nxt;
    end
    top_r      <= top_nxt;
    fwd_data_r <= top_r;
  end

  pmpe_ram #(
    .WIDTH (STK_ENTRY_W),
    .DEPTH (MAX_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (top_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign depth = depth_r;
  assign top   = top_r;

endmodule
